@@ rtl/mdc_pkg.sv @@
// Package for the metadata datagram chunker: field widths, header constants,
// register indexes and the sequencer and mode types.
// Depends on nothing; every other file imports it.
package mdc_pkg;

    localparam int TAG_W             = 32;
    localparam int LEN_IN_W          = 24;
    localparam int BYTE_W            = 8;
    localparam int SIZE_W            = 16;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int HDR_CNT_W         = 5;

    localparam int DEF_LENGTH_BITS   = 24;
    localparam int DEF_CAPACITY_BITS = 16;
    localparam int CAP_RESET         = 500;

    localparam int CHUNK_HDR_BYTES   = 24;
    localparam int SINGLE_HDR_BYTES  = 8;
    localparam int SINGLE_HDR_START  = CHUNK_HDR_BYTES - SINGLE_HDR_BYTES;
    localparam logic [63:0] CHUNK_MAGIC = 64'h7373_6E63_6368_6E6B;

    localparam logic REG_ENABLE   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic ACT_BEGIN   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    typedef enum logic [3:0] {
        S_WAIT = 4'b0001,
        S_DIV  = 4'b0010,
        S_OPEN = 4'b0100,
        S_HDR  = 4'b1000
    } t_seq;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_SINGLE  = 3'b010,
        MODE_CHUNKED = 3'b100
    } t_mode;

endpackage

@@ rtl/mdc_divider.sv @@
// Restoring divider for the chunk count: one quotient bit per cycle.
// Depends on mdc_pkg only for the default widths; parameters set all widths.
module mdc_divider
    import mdc_pkg::*;
#(
    parameter int DIVIDEND_W = DEF_LENGTH_BITS,
    parameter int DIVISOR_W  = DEF_CAPACITY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? DIVISOR_W'(w_trial - {1'b0, r_div}) : w_trial[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/metadata_datagram_chunker_unit.sv @@
// Top level of the metadata datagram chunker: APB registers, sequencer,
// header byte selection and output register.
// Depends on mdc_pkg and mdc_divider.
//
// Input items arrive on i_in_valid/o_in_ready. A begin item (action 0) carries
// type, code and length; a payload item (action 1) carries one byte. Results
// leave one byte per item on o_out_valid/i_out_ready, with the datagram size
// and start, end of packet, end of item and last of run flags.
// A begin for a single datagram moves to S_HDR when it is taken, which gives
// 8 header bytes, one per cycle while the output side does not stall. A begin
// that needs chunks runs the restoring divider in S_DIV to get the chunk
// count, opens the chunk in S_OPEN, then gives 24 header bytes.
// A payload item is taken and its byte registered in the same cycle, so payload
// bytes flow at one per cycle while the output side does not stall; a byte that
// closes a non-final chunk is followed by S_OPEN and the 24-byte next chunk header.
// The block is not ready while it divides, opens a chunk or sends a header, or
// while the output register holds a byte the receiver has not taken; a stall
// on the output side simply holds the sequencer. Reset clears the sequencer,
// the output valid flag and the item state, sets enable to 0 and capacity to 500.
// Any register write abandons the item in progress.
module metadata_datagram_chunker_unit
    import mdc_pkg::*;
#(
    parameter int LENGTH_BITS   = DEF_LENGTH_BITS,
    parameter int CAPACITY_BITS = DEF_CAPACITY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [TAG_W-1:0]      i_item_type,
    input  logic [TAG_W-1:0]      i_item_code,
    input  logic [LEN_IN_W-1:0]   i_item_length,
    input  logic [BYTE_W-1:0]     i_payload_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_packet_byte,
    output logic [SIZE_W-1:0]     o_packet_size,
    output logic                  o_start_of_packet,
    output logic                  o_end_of_packet,
    output logic                  o_end_of_item,
    output logic                  o_last_of_run
);

    localparam int LW = (LENGTH_BITS < LEN_IN_W) ? LENGTH_BITS : LEN_IN_W;
    localparam int CW = SIZE_W;

    t_seq                  r_seq, n_seq;
    t_mode                 r_mode, n_mode;
    logic                  r_en, n_en;
    logic [CW-1:0]         r_cap, n_cap;
    logic [TAG_W-1:0]      r_type, n_type;
    logic [TAG_W-1:0]      r_code, n_code;
    logic [LW-1:0]         r_br, n_br;
    logic [LW-1:0]         r_cidx, n_cidx;
    logic [LW-1:0]         r_ccnt, n_ccnt;
    logic [CW-1:0]         r_cbl, n_cbl;
    logic [SIZE_W-1:0]     r_pkt_size, n_pkt_size;
    logic [HDR_CNT_W-1:0]  r_hcnt, n_hcnt;
    logic                  r_hfirst, n_hfirst;
    logic                  r_empty, n_empty;

    logic                  r_ov, n_ov;
    logic [BYTE_W-1:0]     r_ob, n_ob;
    logic [SIZE_W-1:0]     r_osz, n_osz;
    logic                  r_osop, n_osop;
    logic                  r_oeop, n_oeop;
    logic                  r_oeoi, n_oeoi;
    logic                  r_olor, n_olor;

    logic                  w_slot;
    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [LW-1:0]         w_len;
    logic                  w_len_ok;
    logic [CW-1:0]         w_p;
    logic [CW-1:0]         w_dl;
    logic                  w_chunk_done;
    logic                  w_item_done;
    logic                  w_hlast;
    logic [TAG_W-1:0]      w_hword;
    logic [BYTE_W-1:0]     w_hbyte;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [LW-1:0]         w_quo;
    logic [CW-1:0]         w_rem;

    mdc_divider #(
        .DIVIDEND_W (LW),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_len),
        .i_divisor   (w_p),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(r_cap) : CFG_DATA_W'(r_en);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    assign w_slot     = !r_ov || i_out_ready;
    assign o_in_ready = (r_seq == S_WAIT) && w_slot;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_len      = i_item_length[LW-1:0];
    assign w_len_ok   = ((32'(i_item_length) >> LENGTH_BITS) == 32'd0);
    assign w_p        = r_cap - CW'(CHUNK_HDR_BYTES);
    assign w_dl       = (r_br < LW'(w_p)) ? r_br[CW-1:0] : w_p;
    assign w_chunk_done = (r_cbl == CW'(1));
    assign w_item_done  = w_chunk_done && (r_br == LW'(w_dl));
    assign w_hlast    = (r_hcnt == HDR_CNT_W'(CHUNK_HDR_BYTES - 1));

    always_comb begin
        case (r_hcnt[4:2])
            3'd0:    w_hword = CHUNK_MAGIC[63:32];
            3'd1:    w_hword = CHUNK_MAGIC[31:0];
            3'd2:    w_hword = TAG_W'(r_cidx);
            3'd3:    w_hword = TAG_W'(r_ccnt);
            3'd4:    w_hword = r_type;
            3'd5:    w_hword = r_code;
            default: w_hword = '0;
        endcase
        case (r_hcnt[1:0])
            2'd0:    w_hbyte = w_hword[31:24];
            2'd1:    w_hbyte = w_hword[23:16];
            2'd2:    w_hbyte = w_hword[15:8];
            default: w_hbyte = w_hword[7:0];
        endcase
    end

    always_comb begin
        n_seq       = r_seq;
        n_mode      = r_mode;
        n_en        = r_en;
        n_cap       = r_cap;
        n_type      = r_type;
        n_code      = r_code;
        n_br        = r_br;
        n_cidx      = r_cidx;
        n_ccnt      = r_ccnt;
        n_cbl       = r_cbl;
        n_pkt_size  = r_pkt_size;
        n_hcnt      = r_hcnt;
        n_hfirst    = r_hfirst;
        n_empty     = r_empty;
        n_ov        = r_ov && !i_out_ready;
        n_ob        = r_ob;
        n_osz       = r_osz;
        n_osop      = r_osop;
        n_oeop      = r_oeop;
        n_oeoi      = r_oeoi;
        n_olor      = r_olor;
        w_div_start = 1'b0;

        unique case (r_seq)
            S_WAIT: begin
                if (w_accept && i_action == ACT_BEGIN) begin
                    n_mode = MODE_IDLE;
                    if (r_en && r_cap > CW'(CHUNK_HDR_BYTES) && w_len_ok) begin
                        n_type = i_item_type;
                        n_code = i_item_code;
                        n_br   = w_len;
                        if (w_len < LW'(r_cap) - LW'(SINGLE_HDR_BYTES)) begin
                            n_pkt_size = SIZE_W'(w_len) + SIZE_W'(SINGLE_HDR_BYTES);
                            n_cbl      = w_len[CW-1:0];
                            n_empty    = (w_len == '0);
                            n_mode     = (w_len == '0) ? MODE_IDLE : MODE_SINGLE;
                            n_hcnt     = HDR_CNT_W'(SINGLE_HDR_START);
                            n_hfirst   = 1'b1;
                            n_seq      = S_HDR;
                        end else begin
                            n_cidx      = '0;
                            n_mode      = MODE_CHUNKED;
                            w_div_start = 1'b1;
                            n_seq       = S_DIV;
                        end
                    end
                end else if (w_accept && r_mode != MODE_IDLE) begin
                    n_ov   = 1'b1;
                    n_ob   = i_payload_byte;
                    n_osz  = r_pkt_size;
                    n_osop = 1'b0;
                    n_cbl  = r_cbl - 1'b1;
                    if (r_mode == MODE_SINGLE) begin
                        n_oeop = w_chunk_done;
                        n_oeoi = w_chunk_done;
                        n_olor = 1'b1;
                        if (w_chunk_done) begin
                            n_mode = MODE_IDLE;
                        end
                    end else begin
                        n_oeop = w_chunk_done;
                        n_oeoi = w_item_done;
                        n_olor = !(w_chunk_done && !w_item_done);
                        if (w_chunk_done) begin
                            n_br   = r_br - LW'(w_dl);
                            n_cidx = r_cidx + 1'b1;
                            if (w_item_done) begin
                                n_mode = MODE_IDLE;
                            end else begin
                                n_seq = S_OPEN;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_ccnt = w_quo + LW'(w_rem != '0);
                    n_seq  = S_OPEN;
                end
            end
            S_OPEN: begin
                n_cbl      = w_dl;
                n_pkt_size = SIZE_W'(w_dl) + SIZE_W'(CHUNK_HDR_BYTES);
                n_empty    = 1'b0;
                n_hcnt     = '0;
                n_hfirst   = 1'b1;
                n_seq      = S_HDR;
            end
            S_HDR: begin
                if (w_slot) begin
                    n_ov     = 1'b1;
                    n_ob     = w_hbyte;
                    n_osz    = r_pkt_size;
                    n_osop   = r_hfirst;
                    n_oeop   = w_hlast && r_empty;
                    n_oeoi   = w_hlast && r_empty;
                    n_olor   = w_hlast;
                    n_hfirst = 1'b0;
                    n_hcnt   = r_hcnt + 1'b1;
                    if (w_hlast) begin
                        n_seq = S_WAIT;
                    end
                end
            end
            default: begin
                n_seq = S_WAIT;
            end
        endcase

        if (w_cfg_wr) begin
            n_mode = MODE_IDLE;
            if (paddr[2] == REG_ENABLE) begin
                n_en = pwdata[0];
            end else begin
                n_cap = CW'(pwdata[CAPACITY_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= S_WAIT;
            r_mode     <= MODE_IDLE;
            r_en       <= 1'b0;
            r_cap      <= CW'(CAP_RESET);
            r_type     <= '0;
            r_code     <= '0;
            r_br       <= '0;
            r_cidx     <= '0;
            r_ccnt     <= '0;
            r_cbl      <= '0;
            r_pkt_size <= '0;
            r_hcnt     <= '0;
            r_hfirst   <= 1'b0;
            r_empty    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_mode     <= n_mode;
            r_en       <= n_en;
            r_cap      <= n_cap;
            r_type     <= n_type;
            r_code     <= n_code;
            r_br       <= n_br;
            r_cidx     <= n_cidx;
            r_ccnt     <= n_ccnt;
            r_cbl      <= n_cbl;
            r_pkt_size <= n_pkt_size;
            r_hcnt     <= n_hcnt;
            r_hfirst   <= n_hfirst;
            r_empty    <= n_empty;
            r_ov       <= n_ov;
        end
        r_ob   <= n_ob;
        r_osz  <= n_osz;
        r_osop <= n_osop;
        r_oeop <= n_oeop;
        r_oeoi <= n_oeoi;
        r_olor <= n_olor;
    end

    assign o_out_valid       = r_ov;
    assign o_packet_byte     = r_ob;
    assign o_packet_size     = r_osz;
    assign o_start_of_packet = r_osop;
    assign o_end_of_packet   = r_oeop;
    assign o_end_of_item     = r_oeoi;
    assign o_last_of_run     = r_olor;

    a_single_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SINGLE) |-> (r_cbl != '0))
        else $error("single datagram open with no payload bytes due");

    a_chunk_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_WAIT && r_mode == MODE_CHUNKED) |-> (r_cidx < r_ccnt))
        else $error("chunk index reached chunk count with item still open");

    a_end_of_item_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_item) |-> (o_end_of_packet && o_last_of_run))
        else $error("end of item without end of packet and last of run");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_seq == S_DIV))
        else $error("divider finished outside the divide step");

    a_header_start_sop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_OPEN) |=> (r_seq == S_HDR && r_hfirst))
        else $error("chunk header did not start with start of packet");

endmodule
